>>> sv/multi_channel_echo_ranger_core_macros.svh
// Assertion macros shared by the echo ranger RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef MULTI_CHANNEL_ECHO_RANGER_CORE_MACROS_SVH
`define MULTI_CHANNEL_ECHO_RANGER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCER_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCER_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/mcer_pkg.sv
// Shared types and constants of the echo ranger.
// Depends on nothing; imported by every module of the block.
package mcer_pkg;

    typedef enum logic [1:0] {
        CMD_POLL    = 2'd0,
        CMD_CAPTURE = 2'd1,
        CMD_READ    = 2'd2,
        CMD_UNUSED  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_TRIGGER = 2'd0,
        KIND_MEASURE = 2'd1,
        KIND_READ    = 2'd2,
        KIND_UNUSED  = 2'd3
    } t_kind;

    localparam int unsigned GAP_RESET  = 30;
    localparam int unsigned US_PER_CM  = 58;
    localparam int unsigned CM_MAX     = 255;
    localparam int unsigned WIDTH_MAX  = 65535;
    localparam int unsigned SAT_SPAN   = (CM_MAX + 1) * US_PER_CM;
    localparam int unsigned CM_SHIFT   = 20;
    localparam int unsigned CM_RECIP   = ((1 << CM_SHIFT) + US_PER_CM - 1) / US_PER_CM;

    typedef struct packed {
        logic       fire;
        logic [1:0] target;
    } t_trig;

    typedef struct packed {
        logic        done;
        logic [7:0]  cm;
        logic [15:0] width;
        logic [7:0]  rd_cm;
    } t_echo;

endpackage

>>> sv/mcer_trigger.sv
// Round-robin trigger scheduler: gap check against the last trigger time.
// Depends on mcer_pkg.
module mcer_trigger import mcer_pkg::*; #(
    parameter int SENSORS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [31:0] i_now_ms,
    input  logic [7:0]  i_gap_ms,
    output t_trig       o_trig
);

    localparam int SIDX_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;

    logic [SIDX_W-1:0] r_next;
    logic [SIDX_W-1:0] n_next;
    logic [31:0]       r_last;
    logic [31:0]       elapsed;

    always_comb begin
        elapsed       = i_now_ms - r_last;
        o_trig.fire   = (elapsed >= {24'd0, i_gap_ms});
        o_trig.target = 2'(r_next);
        if (r_next == SIDX_W'(SENSORS - 1)) begin
            n_next = '0;
        end else begin
            n_next = r_next + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next <= '0;
            r_last <= '0;
        end else if (i_step && o_trig.fire) begin
            r_next <= n_next;
            r_last <= i_now_ms;
        end
    end

endmodule

>>> sv/mcer_echo.sv
// Per-sensor edge pairing, echo width and centimetre conversion.
// Depends on mcer_pkg.
module mcer_echo import mcer_pkg::*; #(
    parameter int SENSORS    = 3,
    parameter int TIMER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_capture,
    input  logic [1:0]  i_sensor,
    input  logic [15:0] i_capture_value,
    output t_echo       o_echo
);

    localparam int SIDX_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;

    logic [SENSORS-1:0]    r_await;
    logic [TIMER_BITS-1:0] r_start [SENSORS];
    logic [7:0]            r_dist  [SENSORS];

    logic                  in_rng;
    logic [SIDX_W-1:0]     sidx;
    logic [31:0]           cap_ext;
    logic [TIMER_BITS-1:0] val;
    logic [TIMER_BITS-1:0] start;
    logic [TIMER_BITS-1:0] span;
    logic [31:0]           span_ext;
    logic [28:0]           prod;

    always_comb begin
        in_rng   = (32'(i_sensor) < SENSORS);
        sidx     = SIDX_W'(i_sensor);
        cap_ext  = 32'(i_capture_value);
        val      = cap_ext[TIMER_BITS-1:0];
        start    = in_rng ? r_start[sidx] : '0;
        span     = val - start;
        span_ext = 32'(span);
        prod     = 29'(span_ext[13:0]) * 29'(CM_RECIP);

        o_echo.done = in_rng && r_await[sidx];
        if (span_ext >= 32'(SAT_SPAN)) begin
            o_echo.cm = 8'(CM_MAX);
        end else begin
            o_echo.cm = prod[CM_SHIFT+7:CM_SHIFT];
        end
        if (span_ext > 32'(WIDTH_MAX)) begin
            o_echo.width = 16'(WIDTH_MAX);
        end else begin
            o_echo.width = span_ext[15:0];
        end
        o_echo.rd_cm = in_rng ? r_dist[sidx] : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await <= '0;
            for (int i = 0; i < SENSORS; i++) begin
                r_start[i] <= '0;
                r_dist[i]  <= '0;
            end
        end else if (i_capture && in_rng) begin
            if (!r_await[sidx]) begin
                r_start[sidx] <= val;
                r_await[sidx] <= 1'b1;
            end else begin
                r_dist[sidx]  <= o_echo.cm;
                r_await[sidx] <= 1'b0;
            end
        end
    end

endmodule

>>> sv/multi_channel_echo_ranger_core.sv
// Top level of the three-channel ultrasonic echo ranger.
// Depends on mcer_pkg, mcer_trigger, mcer_echo and the assertion macros.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one command per transfer:
//   a trigger poll with the millisecond time, a capture edge with a sensor
//   and a timer value, or a read of a sensor's stored distance.
//   Output channel (o_out_valid / i_out_ready) carries at most one result
//   per command: a trigger issued, a new measurement or a read reply.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes the minimum
//   trigger gap in milliseconds; it is always ready.
//   A command is held in an input register and evaluated from there; its
//   result is written to the output register once that register is free.
//   One command is taken per cycle unless a result stalls; the rate is set by
//   the single pass from input register to output register, updating state.
//   While the receiver stalls with a result waiting, the output register
//   holds it; the input register still accepts one command, after which
//   o_in_ready falls until the result is taken.
//   Reset clears all channel state, sets the gap to 30 ms and starts the
//   round robin at the left sensor.
`include "multi_channel_echo_ranger_core_macros.svh"

module multi_channel_echo_ranger_core import mcer_pkg::*; #(
    parameter int SENSORS    = 3,
    parameter int TIMER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_now_ms,
    input  logic [1:0]  i_sensor,
    input  logic [15:0] i_capture_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_event_kind,
    output logic [1:0]  o_target_sensor,
    output logic [7:0]  o_range_cm,
    output logic [15:0] o_echo_width_us,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    logic        r_in_vld;
    t_cmd        r_cmd;
    logic [31:0] r_now;
    logic [1:0]  r_sensor;
    logic [15:0] r_cap;

    logic        r_out_vld;
    t_kind       r_kind;
    logic [1:0]  r_target;
    logic [7:0]  r_dist;
    logic [15:0] r_width;

    logic [7:0]  r_gap;

    logic        out_free;
    logic        adv;
    logic        emit;
    t_kind       n_kind;
    logic [1:0]  n_target;
    logic [7:0]  n_dist;
    logic [15:0] n_width;
    t_trig       trig;
    t_echo       echo;

    assign out_free    = !r_out_vld || i_out_ready;
    assign adv         = r_in_vld && out_free;
    assign o_in_ready  = !r_in_vld || adv;
    assign o_cfg_ready = 1'b1;

    mcer_trigger #(
        .SENSORS (SENSORS)
    ) u_trigger (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (adv && (r_cmd == CMD_POLL)),
        .i_now_ms (r_now),
        .i_gap_ms (r_gap),
        .o_trig   (trig)
    );

    mcer_echo #(
        .SENSORS    (SENSORS),
        .TIMER_BITS (TIMER_BITS)
    ) u_echo (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_capture       (adv && (r_cmd == CMD_CAPTURE)),
        .i_sensor        (r_sensor),
        .i_capture_value (r_cap),
        .o_echo          (echo)
    );

    always_comb begin
        emit     = 1'b0;
        n_kind   = KIND_TRIGGER;
        n_target = r_sensor;
        n_dist   = 8'd0;
        n_width  = 16'd0;
        case (r_cmd)
            CMD_POLL: begin
                emit     = trig.fire;
                n_target = trig.target;
            end
            CMD_CAPTURE: begin
                emit    = echo.done;
                n_kind  = KIND_MEASURE;
                n_dist  = echo.cm;
                n_width = echo.width;
            end
            CMD_READ: begin
                emit   = 1'b1;
                n_kind = KIND_READ;
                n_dist = echo.rd_cm;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_gap     <= 8'(GAP_RESET);
        end else begin
            if (i_cfg_valid) begin
                r_gap <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (adv) begin
                r_out_vld <= emit;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd    <= t_cmd'(i_command);
            r_now    <= i_now_ms;
            r_sensor <= i_sensor;
            r_cap    <= i_capture_value;
        end
        if (adv && emit) begin
            r_kind   <= n_kind;
            r_target <= n_target;
            r_dist   <= n_dist;
            r_width  <= n_width;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_event_kind    = r_kind;
    assign o_target_sensor = r_target;
    assign o_range_cm      = r_dist;
    assign o_echo_width_us = r_width;

    `MCER_ASSERT_IMP(a_trig_zero, i_clk, i_rst_n, o_out_valid && (r_kind == KIND_TRIGGER), (o_range_cm == 8'd0) && (o_echo_width_us == 16'd0), "trigger result carries a distance or width")
    `MCER_ASSERT_IMP(a_read_zero, i_clk, i_rst_n, o_out_valid && (r_kind == KIND_READ), o_echo_width_us == 16'd0, "read reply carries an echo width")
    `MCER_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, !o_in_ready, r_in_vld && o_out_valid && !i_out_ready, "input stalled without a blocked result")
    `MCER_ASSERT_NXT(a_fire_emits, i_clk, i_rst_n, adv && (r_cmd == CMD_POLL) && trig.fire, o_out_valid && (r_kind == KIND_TRIGGER), "fired trigger poll produced no trigger result")

endmodule
